FILE: rtl/core/vdg_pkg.sv
package vdg_pkg;

  localparam int GridDim = 32;
  localparam int IdxW = $clog2(GridDim);
  localparam int AddrW = 3 * IdxW;
  localparam int Depth = GridDim * GridDim * GridDim;

  localparam logic [2:0] OpWrite = 3'd0;
  localparam logic [2:0] OpFill = 3'd1;
  localparam logic [2:0] OpLineAvg = 3'd2;
  localparam logic [2:0] OpLineMax = 3'd3;
  localparam logic [2:0] OpSample = 3'd4;
  localparam logic [2:0] OpRead = 3'd5;
  localparam logic [2:0] OpInterp = 3'd6;

  localparam logic [16:0] Q16One = 17'h10000;
  localparam logic [25:0] Q24One = 26'h1000000;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [AddrW-1:0] addr_t;

  function automatic addr_t cell_addr(idx_t x, idx_t y, idx_t z);
    cell_addr = {x, y, z};
  endfunction

endpackage

FILE: rtl/core/vdg_ram.sv
module vdg_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/core/voxel_density_grid_engine.sv
// Voxel density grid engine. A cubic grid of 32x32x32 8-bit densities sits in
// one synchronous RAM with one read and one write port. Every operation is
// sequenced on that memory, so one transaction is taken at a time and the input
// stalls until the previous one is fully done, including its result. After
// reset the block sweeps the whole grid to zero, one cell per cycle, and
// accepts no transaction until the sweep is done; the fill operation runs the
// same sweep. A cell write and an ignored transaction leave the block idle. A
// line begin computes the three deltas in turn on one shared serial divider. A
// line sample passes through its index, check and update states. Each cell
// flush adds a read-modify-write, plus a divide in average mode. A sample that
// leaves a cell and is also the last of its line flushes twice. A cell read
// presents its result through a wait and an output state. An interpolated read
// presents its result after memory reads for the eight neighbours, 7 multiply
// stages and an output step. The result waits in a one-entry output register,
// and no new transaction is accepted until it has been taken.
module voxel_density_grid_engine (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata from bit 0: cell_x(5) cell_y(5) cell_z(5) pos_x(17) pos_y(17)
  // pos_z(17) end_x(17) end_y(17) end_z(17) sample_count(16) value(8), pad 0
  input  logic [143:0] s_axis_tdata,
  // tuser: operation(3)
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: read_value(8)
  output logic [7:0]   m_axis_tdata,
  // tuser: read_kind(1)
  output logic         m_axis_tuser,
  input  logic         cfg_we_i,
  input  logic [8:0]   cfg_wdata_i
);

  localparam int AW = vdg_pkg::AddrW;
  localparam int IW = vdg_pkg::IdxW;

  localparam logic [4:0] StClear   = 5'd0;
  localparam logic [4:0] StIdle    = 5'd1;
  localparam logic [4:0] StDivIn   = 5'd2;
  localparam logic [4:0] StDiv     = 5'd3;
  localparam logic [4:0] StDivOut  = 5'd4;
  localparam logic [4:0] StSmp     = 5'd5;
  localparam logic [4:0] StFlDiv   = 5'd6;
  localparam logic [4:0] StFlRd    = 5'd7;
  localparam logic [4:0] StFlWait  = 5'd8;
  localparam logic [4:0] StFlMul   = 5'd9;
  localparam logic [4:0] StFlWr    = 5'd10;
  localparam logic [4:0] StSmpUpd  = 5'd11;
  localparam logic [4:0] StRdWait  = 5'd12;
  localparam logic [4:0] StRdOut   = 5'd13;
  localparam logic [4:0] StIpRd    = 5'd14;
  localparam logic [4:0] StIpMul   = 5'd15;
  localparam logic [4:0] StIpOut   = 5'd16;
  localparam logic [4:0] StSmpIdx  = 5'd17;

  logic [4:0] st_q, st_d;

  // Input fields.
  logic [2:0] op;
  logic [4:0] in_cx, in_cy, in_cz;
  logic [16:0] in_px, in_py, in_pz, in_ex, in_ey, in_ez;
  logic [15:0] in_cnt;
  logic [7:0] in_val;
  assign op = s_axis_tuser;
  assign in_cx = s_axis_tdata[4:0];
  assign in_cy = s_axis_tdata[9:5];
  assign in_cz = s_axis_tdata[14:10];
  assign in_px = s_axis_tdata[31:15];
  assign in_py = s_axis_tdata[48:32];
  assign in_pz = s_axis_tdata[65:49];
  assign in_ex = s_axis_tdata[82:66];
  assign in_ey = s_axis_tdata[99:83];
  assign in_ez = s_axis_tdata[116:100];
  assign in_cnt = s_axis_tdata[132:117];
  assign in_val = s_axis_tdata[140:133];

  logic in_fire, out_fire;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  // Memory port.
  logic mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0] mem_wdata, mem_rdata;

  vdg_ram #(.Width(8), .Depth(vdg_pkg::Depth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // Registers.
  logic [8:0] weight_q;
  logic [AW:0] sweep_q, sweep_d;
  logic [7:0] fill_q, fill_d;
  logic signed [25:0] lpos_q [3];
  logic signed [25:0] lpos_d [3];
  logic signed [25:0] lstep_q [3];
  logic signed [25:0] lstep_d [3];
  logic [16:0] start_q [3];
  logic [16:0] start_d [3];
  logic [16:0] stop_q [3];
  logic [16:0] stop_d [3];
  logic [AW-1:0] prev_q, prev_d, cur_q, cur_d;
  logic pvalid_q, pvalid_d, active_q, active_d, maxm_q, maxm_d;
  logic [23:0] acc_q, acc_d;
  logic [15:0] cnt_q, cnt_d, left_q, left_d;
  logic [7:0] sval_q, sval_d;
  logic [1:0] axis_q, axis_d;
  // Serial restoring divider.
  logic [24:0] dnum_q, dnum_d;
  logic [16:0] drem_q, drem_d;
  logic [4:0] dcnt_q, dcnt_d;
  logic dneg_q, dneg_d;
  logic [7:0] fval_q, fval_d;
  logic [16:0] mul_q, mul_d;
  // Interpolation.
  logic [IW-1:0] i0_q [3];
  logic [IW-1:0] i0_d [3];
  logic [IW-1:0] i1_q [3];
  logic [IW-1:0] i1_d [3];
  logic [15:0] fr_q [3];
  logic [15:0] fr_d [3];
  logic [3:0] rcnt_q, rcnt_d;
  logic [7:0] cval_q [8];
  logic [7:0] cval_d [8];
  logic [2:0] mstep_q, mstep_d;
  logic [55:0] lin_q [4];
  logic [55:0] lin_d [4];
  logic ovalid_q, ovalid_d, okind_q, okind_d;
  logic [7:0] oval_q, oval_d;

  assign s_axis_tready = (st_q == StIdle) && !ovalid_q;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = oval_q;
  assign m_axis_tuser = okind_q;

  function automatic logic [16:0] sat_pos(logic [16:0] v);
    sat_pos = (v > vdg_pkg::Q16One) ? vdg_pkg::Q16One : v;
  endfunction

  function automatic logic [IW-1:0] sat_idx(logic [4:0] v);
    logic [5:0] w;
    w = {1'b0, v};
    sat_idx = (w > 6'(vdg_pkg::GridDim - 1)) ? IW'(vdg_pkg::GridDim - 1) : IW'(v);
  endfunction

  function automatic logic [IW-1:0] line_idx(logic signed [25:0] p);
    logic [24:0] c;
    logic [30:0] m;
    if (p < 0) begin
      c = '0;
    end else if (p > $signed(vdg_pkg::Q24One)) begin
      c = vdg_pkg::Q24One[24:0];
    end else begin
      c = p[24:0];
    end
    m = 31'(c) * 31'(vdg_pkg::GridDim - 1);
    line_idx = m[24 +: IW];
  endfunction

  // Interpolation lane index: bit 0 selects x, bit 1 y, bit 2 z neighbour.
  function automatic logic [AW-1:0] ip_addr(logic [2:0] n, logic [IW-1:0] a0 [3],
                                            logic [IW-1:0] a1 [3]);
    ip_addr = vdg_pkg::cell_addr(n[0] ? a1[0] : a0[0], n[1] ? a1[1] : a0[1],
                                 n[2] ? a1[2] : a0[2]);
  endfunction

  logic [IW-1:0] lidx [3];
  logic [AW-1:0] smp_addr;
  logic [16:0] divisor;
  logic [17:0] dtrial;
  logic [16:0] ds, de;
  logic [16:0] dmag;
  logic [22:0] ipp [3];
  logic [8:0] wsat;
  logic [7:0] dq8;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lidx[k] = line_idx(lpos_q[k]);
      ipp[k] = 23'(sat_pos(k == 0 ? in_px : (k == 1 ? in_py : in_pz)))
               * 23'(vdg_pkg::GridDim);
    end
    smp_addr = vdg_pkg::cell_addr(lidx[0], lidx[1], lidx[2]);
    wsat = (weight_q > 9'd256) ? 9'd256 : weight_q;
    dq8 = dnum_q[7:0];
    ds = start_q[axis_q];
    de = stop_q[axis_q];
    dmag = (de >= ds) ? de - ds : ds - de;
    divisor = (st_q == StFlDiv) ? {1'b0, cnt_q} : {1'b0, left_q};
    dtrial = {drem_q, dnum_q[24]} - {1'b0, divisor};
  end

  always_comb begin
    st_d = st_q;
    sweep_d = sweep_q;
    fill_d = fill_q;
    lpos_d = lpos_q;
    lstep_d = lstep_q;
    start_d = start_q;
    stop_d = stop_q;
    prev_d = prev_q;
    cur_d = cur_q;
    pvalid_d = pvalid_q;
    active_d = active_q;
    maxm_d = maxm_q;
    acc_d = acc_q;
    cnt_d = cnt_q;
    left_d = left_q;
    sval_d = sval_q;
    axis_d = axis_q;
    dnum_d = dnum_q;
    drem_d = drem_q;
    dcnt_d = dcnt_q;
    dneg_d = dneg_q;
    fval_d = fval_q;
    mul_d = mul_q;
    i0_d = i0_q;
    i1_d = i1_q;
    fr_d = fr_q;
    rcnt_d = rcnt_q;
    cval_d = cval_q;
    mstep_d = mstep_q;
    lin_d = lin_q;
    ovalid_d = ovalid_q && !out_fire;
    okind_d = okind_q;
    oval_d = oval_q;
    mem_we = 1'b0;
    mem_waddr = sweep_q[AW-1:0];
    mem_wdata = fill_q;
    mem_raddr = cur_q;

    case (st_q)
      StClear: begin
        mem_we = 1'b1;
        sweep_d = sweep_q + 1'b1;
        if (sweep_q == (AW + 1)'(vdg_pkg::Depth - 1)) begin
          st_d = StIdle;
        end
      end
      StIdle: begin
        if (in_fire) begin
          case (op)
            vdg_pkg::OpWrite: begin
              mem_we = 1'b1;
              mem_waddr = vdg_pkg::cell_addr(sat_idx(in_cx), sat_idx(in_cy), sat_idx(in_cz));
              mem_wdata = in_val;
            end
            vdg_pkg::OpFill: begin
              fill_d = in_val;
              sweep_d = '0;
              st_d = StClear;
            end
            vdg_pkg::OpLineAvg, vdg_pkg::OpLineMax: begin
              acc_d = '0;
              cnt_d = '0;
              pvalid_d = 1'b0;
              prev_d = '0;
              maxm_d = (op == vdg_pkg::OpLineMax);
              left_d = in_cnt;
              active_d = (in_cnt != 16'd0);
              start_d[0] = sat_pos(in_px);
              start_d[1] = sat_pos(in_py);
              start_d[2] = sat_pos(in_pz);
              stop_d[0] = sat_pos(in_ex);
              stop_d[1] = sat_pos(in_ey);
              stop_d[2] = sat_pos(in_ez);
              for (int k = 0; k < 3; k++) begin
                lpos_d[k] = 26'(start_d[k]) <<< 8;
                lstep_d[k] = '0;
              end
              axis_d = 2'd0;
              if (in_cnt != 16'd0) begin
                st_d = StDivIn;
              end
            end
            vdg_pkg::OpSample: begin
              if (active_q) begin
                sval_d = in_val;
                st_d = StSmpIdx;
              end
            end
            vdg_pkg::OpRead: begin
              // The address is held so the read data stays put until it is taken.
              cur_d = vdg_pkg::cell_addr(sat_idx(in_cx), sat_idx(in_cy), sat_idx(in_cz));
              mem_raddr = cur_d;
              st_d = StRdWait;
            end
            vdg_pkg::OpInterp: begin
              for (int k = 0; k < 3; k++) begin
                i0_d[k] = sat_idx(ipp[k][20:16]);
                i1_d[k] = sat_idx(5'(ipp[k][22:16] + 7'd1 > 7'd31 ? 7'd31
                                      : ipp[k][22:16] + 7'd1));
                if (ipp[k][22:16] > 7'(vdg_pkg::GridDim - 1)) begin
                  i0_d[k] = IW'(vdg_pkg::GridDim - 1);
                end
                if (ipp[k][22:16] + 7'd1 > 7'(vdg_pkg::GridDim - 1)) begin
                  i1_d[k] = IW'(vdg_pkg::GridDim - 1);
                end
                fr_d[k] = ipp[k][15:0];
              end
              rcnt_d = '0;
              st_d = StIpRd;
            end
            default: begin
            end
          endcase
        end
      end
      // Line begin: step = (end - start) * 256 / count, truncated toward zero.
      StDivIn: begin
        dnum_d = {dmag, 8'd0};
        dneg_d = (de < ds);
        drem_d = '0;
        dcnt_d = 5'd25;
        st_d = StDiv;
      end
      StDiv, StFlDiv: begin
        if (!dtrial[17]) begin
          drem_d = dtrial[16:0];
          dnum_d = {dnum_q[23:0], 1'b1};
        end else begin
          drem_d = {drem_q[15:0], dnum_q[24]};
          dnum_d = {dnum_q[23:0], 1'b0};
        end
        dcnt_d = dcnt_q - 1'b1;
        if (dcnt_q == 5'd1) begin
          st_d = (st_q == StDiv) ? StDivOut : StFlRd;
        end
      end
      StDivOut: begin
        lstep_d[axis_q] = dneg_q ? -$signed({1'b0, dnum_q}) : $signed({1'b0, dnum_q});
        axis_d = axis_q + 1'b1;
        st_d = (axis_q == 2'd2) ? StIdle : StDivIn;
      end
      // Line sample: settle cell index from registered position.
      StSmpIdx: begin
        cur_d = smp_addr;
        st_d = StSmp;
      end
      StSmp: begin
        if (pvalid_q && cur_q != prev_q && cnt_q != 16'd0) begin
          cur_d = prev_q;
          dnum_d = {1'b0, acc_q};
          drem_d = '0;
          dcnt_d = 5'd25;
          st_d = maxm_q ? StFlRd : StFlDiv;
        end else begin
          st_d = StSmpUpd;
        end
      end
      StFlRd: begin
        fval_d = maxm_q ? acc_q[7:0] : dq8;
        mem_raddr = cur_q;
        st_d = StFlWait;
      end
      StFlWait: begin
        st_d = StFlMul;
      end
      StFlMul: begin
        mul_d = 17'(wsat) * 17'(fval_q) + 17'(9'd256 - wsat) * 17'(mem_rdata);
        if (mem_rdata == 8'd0) begin
          mul_d = {fval_q, 8'd0};
        end
        st_d = StFlWr;
      end
      StFlWr: begin
        mem_we = 1'b1;
        mem_waddr = cur_q;
        mem_wdata = mul_q[15:8];
        acc_d = '0;
        cnt_d = '0;
        // A flush of the cell just left still has the current sample to take.
        if (pvalid_q) begin
          st_d = StSmpUpd;
          cur_d = smp_addr;
        end else begin
          st_d = StIdle;
          active_d = 1'b0;
          pvalid_d = 1'b0;
        end
      end
      StSmpUpd: begin
        if (maxm_q) begin
          if (24'(sval_q) > acc_q) begin
            acc_d = 24'(sval_q);
          end
        end else begin
          acc_d = acc_q + 24'(sval_q);
        end
        if (cnt_q != 16'hFFFF) begin
          cnt_d = cnt_q + 1'b1;
        end
        prev_d = cur_q;
        pvalid_d = 1'b1;
        for (int k = 0; k < 3; k++) begin
          lpos_d[k] = lpos_q[k] + lstep_q[k];
        end
        if (left_q != 16'd0) begin
          left_d = left_q - 1'b1;
        end
        if (left_q <= 16'd1) begin
          // Last sample: flush the current cell and end the line.
          pvalid_d = 1'b0;
          dnum_d = {1'b0, acc_d};
          drem_d = '0;
          dcnt_d = 5'd25;
          st_d = maxm_q ? StFlRd : StFlDiv;
        end else begin
          st_d = StIdle;
        end
      end
      StRdWait: begin
        st_d = StRdOut;
      end
      StRdOut: begin
        ovalid_d = 1'b1;
        oval_d = mem_rdata;
        okind_d = 1'b0;
        st_d = StIdle;
      end
      StIpRd: begin
        mem_raddr = ip_addr(rcnt_q[2:0], i0_q, i1_q);
        if (rcnt_q != 4'd0) begin
          cval_d[rcnt_q[2:0] - 3'd1] = mem_rdata;
        end
        rcnt_d = rcnt_q + 1'b1;
        if (rcnt_q == 4'd8) begin
          cval_d[7] = mem_rdata;
          mstep_d = '0;
          st_d = StIpMul;
        end
      end
      // One product per cycle: four x lerps, two y lerps, one z lerp.
      StIpMul: begin
        mstep_d = mstep_q + 1'b1;
        case (mstep_q)
          3'd0, 3'd1, 3'd2, 3'd3: begin
            lin_d[mstep_q[1:0]] =
              56'(56'(cval_q[{mstep_q[1:0], 1'b0}]) * (56'(vdg_pkg::Q16One) - 56'(fr_q[0]))
                  + 56'(cval_q[{mstep_q[1:0], 1'b1}]) * 56'(fr_q[0]));
          end
          3'd4: begin
            lin_d[0] = 56'(lin_q[0][23:0]) * (56'(vdg_pkg::Q16One) - 56'(fr_q[1]))
                       + 56'(lin_q[1][23:0]) * 56'(fr_q[1]);
          end
          3'd5: begin
            lin_d[1] = 56'(lin_q[2][23:0]) * (56'(vdg_pkg::Q16One) - 56'(fr_q[1]))
                       + 56'(lin_q[3][23:0]) * 56'(fr_q[1]);
          end
          3'd6: begin
            lin_d[2] = 56'(lin_q[0][39:0]) * (56'(vdg_pkg::Q16One) - 56'(fr_q[2]))
                       + 56'(lin_q[1][39:0]) * 56'(fr_q[2]);
            st_d = StIpOut;
          end
          default: begin
          end
        endcase
      end
      StIpOut: begin
        ovalid_d = 1'b1;
        oval_d = lin_q[2][55:48];
        okind_d = 1'b1;
        st_d = StIdle;
      end
      default: begin
        st_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClear;
      sweep_q <= '0;
      fill_q <= '0;
      weight_q <= 9'd256;
      ovalid_q <= 1'b0;
      active_q <= 1'b0;
      pvalid_q <= 1'b0;
      maxm_q <= 1'b0;
      left_q <= '0;
      cnt_q <= '0;
      acc_q <= '0;
      prev_q <= '0;
      for (int k = 0; k < 3; k++) begin
        lpos_q[k] <= '0;
        lstep_q[k] <= '0;
      end
    end else begin
      st_q <= st_d;
      sweep_q <= sweep_d;
      fill_q <= fill_d;
      if (cfg_we_i) begin
        weight_q <= cfg_wdata_i;
      end
      ovalid_q <= ovalid_d;
      active_q <= active_d;
      pvalid_q <= pvalid_d;
      maxm_q <= maxm_d;
      left_q <= left_d;
      cnt_q <= cnt_d;
      acc_q <= acc_d;
      prev_q <= prev_d;
      lpos_q <= lpos_d;
      lstep_q <= lstep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    stop_q <= stop_d;
    cur_q <= cur_d;
    sval_q <= sval_d;
    axis_q <= axis_d;
    dnum_q <= dnum_d;
    drem_q <= drem_d;
    dcnt_q <= dcnt_d;
    dneg_q <= dneg_d;
    fval_q <= fval_d;
    mul_q <= mul_d;
    i0_q <= i0_d;
    i1_q <= i1_d;
    fr_q <= fr_d;
    rcnt_q <= rcnt_d;
    cval_q <= cval_d;
    mstep_q <= mstep_d;
    lin_q <= lin_d;
    okind_q <= okind_d;
    oval_q <= oval_d;
  end

  // The sweep never accepts a transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StClear) |-> !s_axis_tready)
    else $error("transaction accepted during grid sweep");

  // A finished read always lands in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StRdOut || st_q == StIpOut) |=> m_axis_tvalid)
    else $error("read result lost");

  // No sample is processed without an active line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StSmpIdx) |-> active_q)
    else $error("sample processed with no active line");

  // The read sequences never write the memory.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StIpRd || st_q == StRdWait) |-> !mem_we)
    else $error("write during read sequence");

endmodule
